### rtl/text_console_cursor_engine_top_macros.svh
// Assertion macros used by the console engine top level.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define TCCE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define TCCE_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/tcce_pkg.sv
// Shared widths, codes and defaults for the text console engine.
package tcce_pkg;

	// Field widths of the request and response words.
	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;

	// Default screen geometry.
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Character codes with special handling.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Attribute after reset and the blank written by the power-up clear.
	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

endpackage

### rtl/tcce_if.sv
// Valid/ready channel interfaces for console requests and responses.
interface tcce_in_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, func, char_code, cell_index, input ready);
	modport sink (input valid, func, char_code, cell_index, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cursor_column;
	logic [CELL_W-1:0] cell_data;

	modport source (output valid, cur_row, cursor_column, cell_data, input ready);
	modport sink (input valid, cur_row, cursor_column, cell_data, output ready);
endinterface

### rtl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/text_console_cursor_engine_top.sv
// Top level of the text console engine: sequencer, cursor and screen store.
//
//   channel | dir | word / fields
//   --------+-----+----------------------------------------------
//   req     | in  | func, char_code, cell_index (valid/ready)
//   rsp     | out | cur_row, cursor_column, cell_data (valid/ready)
//   cfg     | in  | cfg_wen, cfg_wdata: text attribute byte
//
// A put holds the request port low after acceptance through the address multiply
// and the RAM write, an in-range read through the registered RAM read. A read past
// the grid or an unused code goes straight to the response. A clear or a scrolling
// put holds it while the single RAM write port walks the grid one cell per cycle.
// After reset a clearing pass over every cell runs first; a stalled response holds
// the sequencer in its final state, though one new word is accepted meanwhile.
`include "text_console_cursor_engine_top_macros.svh"

module text_console_cursor_engine_top import tcce_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tcce_in_if.sink           req,
	tcce_out_if.source        rsp,
	input  logic              cfg_wen,
	input  logic [ATTR_W-1:0] cfg_wdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);

	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0] CELL_LAST  = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] FILL_START = AW'(CELL_COUNT - COLUMNS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

	// One-hot sequencer states.
	typedef enum logic [10:0] {
		S_INIT   = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_EXEC   = 11'b000_0000_0100,
		S_ADDR   = 11'b000_0000_1000,
		S_WRITE  = 11'b000_0001_0000,
		S_SCROLL = 11'b000_0010_0000,
		S_DRAIN  = 11'b000_0100_0000,
		S_FILL   = 11'b000_1000_0000,
		S_READ   = 11'b001_0000_0000,
		S_RCAP   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t             state_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      dst_q;
	logic               copy_v_q;
	logic [FUNC_W-1:0]  func_q;
	logic [CHAR_W-1:0]  char_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RW-1:0]      tgt_row_q;
	logic [CW-1:0]      tgt_col_q;
	logic               wr_q;
	logic               scroll_q;
	logic [CELL_W-1:0]  wdata_q;
	logic [CELL_W-1:0]  data_q;
	logic               rsp_valid_q;
	logic [ROW_W-1:0]   rsp_row_q;
	logic [COL_W-1:0]   rsp_col_q;
	logic [CELL_W-1:0]  rsp_data_q;

	logic [CELL_W-1:0]  blank;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic [CELL_W-1:0]  mem_rdata;

	logic [RW-1:0]      put_row_n;
	logic [CW-1:0]      put_col_n;
	logic [RW-1:0]      put_tgt_row;
	logic [CW-1:0]      put_tgt_col;
	logic               put_wr;
	logic               put_scroll;
	logic [CELL_W-1:0]  put_data;
	logic [31:0]        row_ext;
	logic [31:0]        col_ext;

	assign blank = {attr_q, CH_SPACE};

	// Cursor movement and target cell for a put.
	always_comb begin
		put_row_n   = row_q;
		put_col_n   = col_q;
		put_tgt_row = row_q;
		put_tgt_col = col_q;
		put_wr      = 1'b0;
		put_scroll  = 1'b0;
		put_data    = {attr_q, char_q};
		if (char_q == CH_NEWLINE) begin
			put_col_n = '0;
			if (row_q == LAST_ROW) begin
				put_scroll = 1'b1;
			end else begin
				put_row_n = row_q + RW'(1);
			end
		end else if (char_q == CH_BACKSPACE) begin
			put_data = blank;
			if (col_q != '0) begin
				put_col_n   = col_q - CW'(1);
				put_tgt_col = col_q - CW'(1);
				put_wr      = 1'b1;
			end else if (row_q != '0) begin
				put_row_n   = row_q - RW'(1);
				put_col_n   = LAST_COL;
				put_tgt_row = row_q - RW'(1);
				put_tgt_col = LAST_COL;
				put_wr      = 1'b1;
			end
		end else begin
			put_wr = 1'b1;
			if (col_q == LAST_COL) begin
				put_col_n = '0;
				if (row_q == LAST_ROW) begin
					put_scroll = 1'b1;
				end else begin
					put_row_n = row_q + RW'(1);
				end
			end else begin
				put_col_n = col_q + CW'(1);
			end
		end
	end

	// RAM write port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = blank;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = RESET_BLANK;
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_WRITE: begin
				mem_we    = wr_q;
				mem_wdata = wdata_q;
			end
			S_SCROLL, S_DRAIN: begin
				mem_we    = copy_v_q;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_wen) begin
			attr_q <= cfg_wdata;
		end
	end

	// Sequencer, cursor and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			addr_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			copy_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (addr_q == CELL_LAST) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (func_q)
						FUNC_PUT: begin
							row_q   <= put_row_n;
							col_q   <= put_col_n;
							state_q <= S_ADDR;
						end
						FUNC_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							addr_q  <= '0;
							state_q <= S_FILL;
						end
						FUNC_READ: begin
							if (32'(idx_q) < CELL_COUNT) begin
								addr_q  <= AW'(idx_q);
								state_q <= S_READ;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_ADDR: begin
					addr_q  <= AW'(tgt_row_q) * COLS_A + AW'(tgt_col_q);
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (scroll_q) begin
						addr_q  <= COLS_A;
						state_q <= S_SCROLL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCROLL: begin
					copy_v_q <= 1'b1;
					if (addr_q == CELL_LAST) begin
						addr_q  <= FILL_START;
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					copy_v_q <= 1'b0;
					state_q  <= S_FILL;
				end
				S_FILL: begin
					if (addr_q == CELL_LAST) begin
						state_q <= S_DONE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_READ: begin
					state_q <= S_RCAP;
				end
				S_RCAP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// Request capture, put target and read data; payload only.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q <= req.func;
			char_q <= req.char_code;
			idx_q  <= req.cell_index;
		end
		if (state_q == S_EXEC) begin
			tgt_row_q <= put_tgt_row;
			tgt_col_q <= put_tgt_col;
			wr_q      <= put_wr && (func_q == FUNC_PUT);
			scroll_q  <= put_scroll;
			wdata_q   <= put_data;
			data_q    <= '0;
		end
		if (state_q == S_SCROLL) begin
			dst_q <= addr_q - COLS_A;
		end
		if (state_q == S_RCAP) begin
			data_q <= mem_rdata;
		end
	end

	// Response register; cursor fields are masked to the port widths.
	assign row_ext = 32'(row_q);
	assign col_ext = 32'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_row_q  <= row_ext[ROW_W-1:0];
			rsp_col_q  <= col_ext[COL_W-1:0];
			rsp_data_q <= data_q;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.cur_row       = rsp_row_q;
	assign rsp.cursor_column = rsp_col_q;
	assign rsp.cell_data     = rsp_data_q;

	// The grid is never written while a new word can be accepted.
	`TCCE_NEVER(a_no_write_when_ready, mem_we && req.ready, "RAM write while request ready")
	// A scroll copy lands exactly one row above the cell read before it.
	`TCCE_ASSERT(a_copy_dest, copy_v_q |-> ((dst_q + COLS_A) == $past(addr_q)), "scroll copy address")
	// The cursor always stays on the grid.
	`TCCE_ASSERT(a_cursor_range, (row_q <= LAST_ROW) && (col_q <= LAST_COL), "cursor off grid")
	// A new response appears only when the sequencer finishes an operation.
	`TCCE_ASSERT(a_rsp_from_done, $rose(rsp.valid) |-> ($past(state_q) == S_DONE), "stray response")

endmodule

### tb/tb.sv
// Self-checking testbench for the text console engine: directed edge cases and random text.
module tb import tcce_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_COUNT = COLUMNS_DEF * ROWS_DEF;
	localparam int IDX_MAX = (1 << IDX_W) - 1;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_CAP = 40;

	// Cursor and cell contents reported for one request word.
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CELL_W-1:0] data;
	} console_view_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [ATTR_W-1:0] cfg_wdata;

	tcce_in_if  req_ch ();
	tcce_out_if rsp_ch ();

	text_console_cursor_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the screen, cursor and attribute register.
	logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
	int unsigned shadow_row;
	int unsigned shadow_col;
	logic [ATTR_W-1:0] shadow_attr;
	console_view_t pending_views [$];

	bit tx_calm;
	bit rx_calm;
	bit hold_responses;
	int fault_count;
	int words_sent;
	int views_checked;
	int put_count, clear_count, read_count, spare_count;
	int scroll_count, wrap_count, attr_writes, holds_done;
	int quiet_cycles;

	// Free-running clock, 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fault_count < REPORT_CAP) begin
			$display("tb: mismatch on %s at response %0d: got 0x%0h, expected 0x%0h",
				what, views_checked, got, want);
		end
		fault_count++;
	endtask

	function automatic logic [CELL_W-1:0] blank_value();
		return {shadow_attr, CH_SPACE};
	endfunction

	function automatic void blank_range(input int first, input int last);
		for (int i = first; i < last; i++) begin
			shadow_cells[i] = blank_value();
		end
	endfunction

	// Every row moves up by one and the bottom row becomes blank.
	function automatic void scroll_screen();
		for (int i = COLUMNS_DEF; i < CELL_COUNT; i++) begin
			shadow_cells[i - COLUMNS_DEF] = shadow_cells[i];
		end
		blank_range(CELL_COUNT - COLUMNS_DEF, CELL_COUNT);
		scroll_count++;
	endfunction

	// Character output with newline, backspace, wrap and scroll handling.
	function automatic void shadow_put(input logic [CHAR_W-1:0] ch);
		if (ch == CH_NEWLINE) begin
			shadow_row++;
			shadow_col = 0;
		end else if (ch == CH_BACKSPACE) begin
			if (shadow_col > 0) begin
				shadow_col--;
			end else if (shadow_row > 0) begin
				shadow_row--;
				shadow_col = COLUMNS_DEF - 1;
			end else begin
				return;
			end
			shadow_cells[shadow_row * COLUMNS_DEF + shadow_col] = blank_value();
		end else begin
			shadow_cells[shadow_row * COLUMNS_DEF + shadow_col] = {shadow_attr, ch};
			shadow_col++;
			if (shadow_col >= COLUMNS_DEF) begin
				shadow_col = 0;
				shadow_row++;
				wrap_count++;
			end
		end
		if (shadow_row >= ROWS_DEF) begin
			scroll_screen();
			shadow_row = ROWS_DEF - 1;
		end
	endfunction

	// Applies one request to the shadow state and returns the expected response.
	function automatic console_view_t console_apply(input logic [FUNC_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		console_view_t view;
		view.data = '0;
		case (op)
			FUNC_PUT: begin
				shadow_put(ch);
				put_count++;
			end
			FUNC_CLEAR: begin
				blank_range(0, CELL_COUNT);
				shadow_row = 0;
				shadow_col = 0;
				clear_count++;
			end
			FUNC_READ: begin
				if (idx < CELL_COUNT) begin
					view.data = shadow_cells[idx];
				end
				read_count++;
			end
			default: begin
				spare_count++;
			end
		endcase
		view.row = shadow_row[ROW_W-1:0];
		view.col = shadow_col[COL_W-1:0];
		return view;
	endfunction

	// Offers one request word after a random gap and waits until it is taken.
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(7, 0);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= op;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		pending_views.push_back(console_apply(op, ch, idx));
		words_sent++;
	endtask

	task automatic put_byte(input logic [CHAR_W-1:0] ch);
		send_word(FUNC_PUT, ch, IDX_W'($urandom_range(IDX_MAX, 0)));
	endtask

	task automatic read_cell(input logic [IDX_W-1:0] idx);
		send_word(FUNC_READ, CHAR_W'($urandom_range(255, 0)), idx);
	endtask

	task automatic clear_screen();
		send_word(FUNC_CLEAR, CHAR_W'($urandom_range(255, 0)),
			IDX_W'($urandom_range(IDX_MAX, 0)));
	endtask

	// Drops valid and waits until every response is in and the block is quiet.
	task automatic settle_block();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		settle_block();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		shadow_attr = value;
		attr_writes++;
	endtask

	// Cells right after reset, reads past the grid and the unused operation.
	task automatic test_reset_contents();
		read_cell(IDX_W'(0));
		read_cell(IDX_W'(CELL_COUNT - 1));
		read_cell(IDX_W'(CELL_COUNT));
		read_cell(IDX_W'(IDX_MAX));
		send_word(FUNC_SPARE, 8'hFF, IDX_W'(IDX_MAX));
	endtask

	// Backspace at the origin and across a row, character extremes, wrap, clear.
	task automatic test_cursor_edges();
		put_byte(CH_BACKSPACE);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(CH_BACKSPACE);
		put_byte(CH_NEWLINE);
		put_byte(CH_BACKSPACE);
		put_byte(8'hA5);
		read_cell(IDX_W'(COLUMNS_DEF - 1));
		read_cell(IDX_W'(1));
		read_cell(IDX_W'(0));
		clear_screen();
		read_cell(IDX_W'(0));
		read_cell(IDX_W'(COLUMNS_DEF - 1));
	endtask

	// Random lines of text: mostly short, some long enough to wrap, with reads mixed in.
	task automatic run_text_stream(input int words);
		int target;
		int dice;
		int line_len;
		int pick;
		target = words_sent + words;
		while (words_sent < target) begin
			dice = $urandom_range(99, 0);
			if (dice < 2) begin
				clear_screen();
			end else if (dice < 5) begin
				send_word(FUNC_SPARE, CHAR_W'($urandom_range(255, 0)),
					IDX_W'($urandom_range(IDX_MAX, 0)));
			end else begin
				// Backspaces at column zero step back into the row above.
				if ($urandom_range(7, 0) == 0) begin
					repeat ($urandom_range(3, 1)) put_byte(CH_BACKSPACE);
				end
				line_len = ($urandom_range(7, 0) == 0) ? $urandom_range(170, 75)
					: $urandom_range(20, 0);
				for (int k = 0; k < line_len; k++) begin
					pick = $urandom_range(15, 0);
					if (pick == 0) begin
						read_cell(IDX_W'(($urandom_range(9, 0) == 0)
							? $urandom_range(IDX_MAX, CELL_COUNT)
							: $urandom_range(CELL_COUNT - 1, 0)));
					end else if (pick == 1) begin
						put_byte(CH_BACKSPACE);
					end else begin
						put_byte(CHAR_W'($urandom_range(255, 0)));
					end
				end
				put_byte(CH_NEWLINE);
				// Look at the bottom rows, where scrolling moves things.
				repeat ($urandom_range(2, 0)) begin
					read_cell(IDX_W'($urandom_range(CELL_COUNT - 1,
						CELL_COUNT - 2 * COLUMNS_DEF)));
				end
			end
		end
	endtask

	task automatic test_back_to_back();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_text_stream(150);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	task automatic test_attribute_extremes();
		set_attribute(8'h00);
		run_text_stream(200);
		set_attribute(8'hFF);
		run_text_stream(150);
	endtask

	// The response side stops for a long stretch while requests keep coming.
	task automatic test_input_stall();
		hold_responses = 1'b1;
		run_text_stream(40);
		holds_done++;
	endtask

	task automatic test_random_attributes();
		set_attribute(ATTR_W'($urandom_range(254, 1)));
		tx_calm = 1'b1;
		run_text_stream(200);
		tx_calm = 1'b0;
		set_attribute(ATTR_W'($urandom_range(254, 1)));
		rx_calm = 1'b1;
		run_text_stream(200);
		rx_calm = 1'b0;
	endtask

	// Response side: random stalls per word, or one long hold when asked.
	initial begin : response_sink
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_responses) begin
				stall = HOLD_CYCLES;
				hold_responses = 1'b0;
			end else begin
				stall = rx_calm ? 0 : $urandom_range(7, 0);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Compare each accepted response word with the oldest expectation.
	always @(posedge clk) begin : check_views
		console_view_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_views.size() == 0) begin
				report_mismatch("unexpected word",
					32'({rsp_ch.cur_row, rsp_ch.cursor_column}), 32'd0);
			end else begin
				want = pending_views.pop_front();
				if (rsp_ch.cur_row !== want.row) begin
					report_mismatch("cur_row", 32'(rsp_ch.cur_row), 32'(want.row));
				end
				if (rsp_ch.cursor_column !== want.col) begin
					report_mismatch("cursor_column", 32'(rsp_ch.cursor_column),
						32'(want.col));
				end
				if (rsp_ch.cell_data !== want.data) begin
					report_mismatch("cell_data", 32'(rsp_ch.cell_data), 32'(want.data));
				end
			end
			views_checked++;
		end
	end

	// Ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_PUT;
		req_ch.char_code  = '0;
		req_ch.cell_index = '0;
		quiet_cycles      = 0;
		shadow_attr       = RESET_ATTR;
		shadow_row        = 0;
		shadow_col        = 0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			shadow_cells[i] = RESET_BLANK;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_cursor_edges();
		test_back_to_back();
		test_attribute_extremes();
		test_input_stall();
		test_random_attributes();

		settle_block();
		$display("tb: %0d words: %0d puts, %0d clears, %0d reads, %0d unused ops",
			words_sent, put_count, clear_count, read_count, spare_count);
		$display("tb: %0d scrolls, %0d wraps, %0d attribute writes, %0d long holds, %0d checked",
			scroll_count, wrap_count, attr_writes, holds_done, views_checked);
		if (fault_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

### text_console_cursor_engine_top.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_if.sv
rtl/tcce_ram.sv
rtl/text_console_cursor_engine_top.sv
tb/tb.sv
